[src/telnet_comport_rx_decoder_defines.svh]
// Assertion macros for the receive decoder, used by the controller module tcrd_ctrl.
`ifndef TELNET_COMPORT_RX_DECODER_DEFINES_SVH
`define TELNET_COMPORT_RX_DECODER_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define TCRD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tcrd: implication check failed");

// Next-cycle implication.
`define TCRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tcrd: next-cycle check failed");

`endif

[src/tcrd_pkg.sv]
// Types, protocol constants and helper functions for the Telnet receive decoder.
`timescale 1ns / 1ps
package tcrd_pkg;

   localparam int SUBNEG_DEPTH = 32;
   localparam int ADDR_W       = $clog2(SUBNEG_DEPTH);
   localparam int CNT_W        = $clog2(SUBNEG_DEPTH + 1);

   localparam logic [7:0] B_IAC  = 8'd255;
   localparam logic [7:0] B_DONT = 8'd254;
   localparam logic [7:0] B_DO   = 8'd253;
   localparam logic [7:0] B_WONT = 8'd252;
   localparam logic [7:0] B_WILL = 8'd251;
   localparam logic [7:0] B_SB   = 8'd250;
   localparam logic [7:0] B_SE   = 8'd240;

   localparam logic [7:0] OPT_COMPORT = 8'd44;
   localparam logic [7:0] OPT_BIN     = 8'd0;
   localparam logic [7:0] OPT_SGA     = 8'd3;

   localparam logic [1:0] CH_DATA  = 2'd0;
   localparam logic [1:0] CH_REPLY = 2'd1;
   localparam logic [1:0] CH_CMD   = 2'd2;

   typedef struct packed {
      logic [1:0] channel;
      logic [7:0] out_byte;
      logic [7:0] command_code;
      logic       has_value;
      logic       truncated;
      logic       last;
      logic       com_port_agreed;
   } rsp_word_type;

   // One-hot flag position of a supported option, zero for any other option.
   function automatic logic [2:0] option_bit(input logic [7:0] opt);
      logic [2:0] bits;
      bits = 3'b000;
      if (opt == OPT_COMPORT) bits = 3'b001;
      if (opt == OPT_BIN)     bits = 3'b010;
      if (opt == OPT_SGA)     bits = 3'b100;
      return bits;
   endfunction

   function automatic rsp_word_type make_word(
      input logic [1:0] channel,
      input logic [7:0] out_byte,
      input logic [7:0] command_code,
      input logic       has_value,
      input logic       truncated,
      input logic       last,
      input logic       agreed
   );
      rsp_word_type w;
      w.channel         = channel;
      w.out_byte        = out_byte;
      w.command_code    = command_code;
      w.has_value       = has_value;
      w.truncated       = truncated;
      w.last            = last;
      w.com_port_agreed = agreed;
      return w;
   endfunction

endpackage

[src/tcrd_subneg_ram.sv]
// Subnegotiation byte buffer: one write port, one registered read port.
`timescale 1ns / 1ps
module tcrd_subneg_ram (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [tcrd_pkg::ADDR_W-1:0] wr_addr,
   input  logic [7:0]                wr_data,
   input  logic                      rd_en,
   input  logic [tcrd_pkg::ADDR_W-1:0] rd_addr,
   output logic [7:0]                rd_data
);
   import tcrd_pkg::*;

   logic [7:0] mem [SUBNEG_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read data holds between reads, so a stalled result keeps its byte.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

[src/tcrd_out_stage.sv]
// Output register between the decoder and the result channel.
`timescale 1ns / 1ps
module tcrd_out_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  tcrd_pkg::rsp_word_type push_word,
   output logic                   out_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tcrd_pkg::rsp_word_type rsp_word
);
   import tcrd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   assign out_ready = !valid_ff || !rsp_stall;
   assign valid_in  = push_valid || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid && out_ready) begin
         word_ff <= push_word;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_word  = word_ff;

endmodule

[src/tcrd_ctrl.sv]
// Telnet parser, option negotiation and subnegotiation read-out sequencer.
`timescale 1ns / 1ps
`include "telnet_comport_rx_decoder_defines.svh"
module tcrd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   output logic                        push_valid,
   output tcrd_pkg::rsp_word_type      push_word,
   input  logic                        out_ready,
   output logic                        ram_wr_en,
   output logic [tcrd_pkg::ADDR_W-1:0] ram_wr_addr,
   output logic [7:0]                  ram_wr_data,
   output logic                        ram_rd_en,
   output logic [tcrd_pkg::ADDR_W-1:0] ram_rd_addr,
   input  logic [7:0]                  ram_rd_data
);
   import tcrd_pkg::*;

   typedef enum logic [2:0] {
      ST_NORMAL,
      ST_IAC,
      ST_NEG,
      ST_SUB,
      ST_SUBIAC,
      ST_REPLY,
      ST_RD,
      ST_PUSH
   } state_type;

   localparam logic [1:0] REP_LAST = 2'd2;

   state_type        state_ff,   state_in;
   logic [7:0]       verb_ff,    verb_in;
   logic [2:0]       will_ff,    will_in;
   logic [2:0]       do_ff,      do_in;
   logic             agreed_ff,  agreed_in;
   logic [CNT_W-1:0] cnt_ff,     cnt_in;
   logic             ovf_ff,     ovf_in;
   logic [7:0]       opt_ff,     opt_in;
   logic [7:0]       code_ff,    code_in;
   logic [CNT_W-1:0] rd_idx_ff,  rd_idx_in;
   logic [1:0]       rep_idx_ff, rep_idx_in;
   logic [7:0]       rep_verb_ff, rep_verb_in;
   logic [7:0]       rep_opt_ff,  rep_opt_in;

   logic       accept;
   logic       busy;
   logic       do_push;
   logic [7:0] push_byte;
   logic [2:0] opt_bit;
   logic       rep_last;
   logic       rd_last;
   logic [7:0] rep_byte;

   assign busy      = (state_ff == ST_REPLY) || (state_ff == ST_RD) || (state_ff == ST_PUSH);
   assign req_stall = busy || !out_ready;
   assign accept    = req_valid && !req_stall;
   assign opt_bit   = option_bit(req_rx_byte);
   assign rep_last  = (rep_idx_ff == REP_LAST);
   assign rd_last   = (rd_idx_ff == cnt_ff - CNT_W'(1));

   always_comb begin
      case (rep_idx_ff)
         2'd0:    rep_byte = B_IAC;
         2'd1:    rep_byte = rep_verb_ff;
         default: rep_byte = rep_opt_ff;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      verb_in     = verb_ff;
      will_in     = will_ff;
      do_in       = do_ff;
      agreed_in   = agreed_ff;
      cnt_in      = cnt_ff;
      ovf_in      = ovf_ff;
      opt_in      = opt_ff;
      code_in     = code_ff;
      rd_idx_in   = rd_idx_ff;
      rep_idx_in  = rep_idx_ff;
      rep_verb_in = rep_verb_ff;
      rep_opt_in  = rep_opt_ff;
      do_push     = 1'b0;
      push_byte   = req_rx_byte;
      push_valid  = 1'b0;
      push_word   = make_word(CH_DATA, req_rx_byte, 8'd0, 1'b0, 1'b0, 1'b1, agreed_ff);
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[ADDR_W-1:0];

      unique case (state_ff)
         ST_NORMAL: begin
            if (accept) begin
               if (req_rx_byte == B_IAC) begin
                  state_in = ST_IAC;
               end else begin
                  push_valid = 1'b1;
               end
            end
         end
         ST_IAC: begin
            if (accept) begin
               state_in = ST_NORMAL;
               if (req_rx_byte == B_IAC) begin
                  push_valid = 1'b1;
               end else if (req_rx_byte == B_SB) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_SUB;
               end else if (req_rx_byte == B_WILL || req_rx_byte == B_WONT ||
                            req_rx_byte == B_DO || req_rx_byte == B_DONT) begin
                  verb_in  = req_rx_byte;
                  state_in = ST_NEG;
               end
            end
         end
         ST_NEG: begin
            if (accept) begin
               state_in   = ST_NORMAL;
               rep_opt_in = req_rx_byte;
               rep_idx_in = 2'd0;
               if (opt_bit != 3'b000) begin
                  case (verb_ff)
                     B_DO: begin
                        if (req_rx_byte == OPT_COMPORT) agreed_in = 1'b1;
                        if ((will_ff & opt_bit) == 3'b000) begin
                           will_in     = will_ff | opt_bit;
                           rep_verb_in = B_WILL;
                           state_in    = ST_REPLY;
                        end
                     end
                     B_WILL: begin
                        if (req_rx_byte == OPT_COMPORT) agreed_in = 1'b1;
                        if ((do_ff & opt_bit) == 3'b000) begin
                           do_in       = do_ff | opt_bit;
                           rep_verb_in = B_DO;
                           state_in    = ST_REPLY;
                        end
                     end
                     B_DONT:  will_in = will_ff & ~opt_bit;
                     B_WONT:  do_in   = do_ff & ~opt_bit;
                     default: ;
                  endcase
               end else if (verb_ff == B_DO) begin
                  rep_verb_in = B_WONT;
                  state_in    = ST_REPLY;
               end else if (verb_ff == B_WILL) begin
                  rep_verb_in = B_DONT;
                  state_in    = ST_REPLY;
               end
            end
         end
         ST_SUB: begin
            if (accept) begin
               if (req_rx_byte == B_IAC) begin
                  state_in = ST_SUBIAC;
               end else begin
                  do_push = 1'b1;
               end
            end
         end
         ST_SUBIAC: begin
            if (accept) begin
               state_in = ST_NORMAL;
               if (req_rx_byte == B_IAC) begin
                  do_push  = 1'b1;
                  push_byte = B_IAC;
                  state_in = ST_SUB;
               end else if (req_rx_byte == B_SE) begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
                  if (cnt_ff >= CNT_W'(2) && opt_ff == OPT_COMPORT) begin
                     if (cnt_ff == CNT_W'(2)) begin
                        push_valid = 1'b1;
                        push_word  = make_word(CH_CMD, 8'd0, code_ff, 1'b0, ovf_ff,
                                               1'b1, agreed_ff);
                     end else begin
                        // Keep the count and overflow until the value bytes are out.
                        cnt_in    = cnt_ff;
                        ovf_in    = ovf_ff;
                        rd_idx_in = CNT_W'(2);
                        state_in  = ST_RD;
                     end
                  end
               end else begin
                  cnt_in = '0;
                  ovf_in = 1'b0;
               end
            end
         end
         ST_REPLY: begin
            if (out_ready) begin
               push_valid = 1'b1;
               push_word  = make_word(CH_REPLY, rep_byte, 8'd0, 1'b0, 1'b0, rep_last,
                                      agreed_ff);
               rep_idx_in = rep_idx_ff + 2'd1;
               if (rep_last) state_in = ST_NORMAL;
            end
         end
         ST_RD: begin
            ram_rd_en = 1'b1;
            state_in  = ST_PUSH;
         end
         ST_PUSH: begin
            if (out_ready) begin
               push_valid = 1'b1;
               push_word  = make_word(CH_CMD, ram_rd_data, code_ff, 1'b1, ovf_ff, rd_last,
                                      agreed_ff);
               if (rd_last) begin
                  cnt_in   = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_NORMAL;
               end else begin
                  rd_idx_in = rd_idx_ff + CNT_W'(1);
                  state_in  = ST_RD;
               end
            end
         end
         default: state_in = ST_NORMAL;
      endcase

      // Buffer append; the option and command bytes are also kept in registers.
      if (do_push) begin
         if (cnt_ff < CNT_W'(SUBNEG_DEPTH)) begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(0)) opt_in  = push_byte;
            if (cnt_ff == CNT_W'(1)) code_in = push_byte;
         end else begin
            ovf_in = 1'b1;
         end
      end
   end

   assign ram_wr_en   = do_push && (cnt_ff < CNT_W'(SUBNEG_DEPTH));
   assign ram_wr_addr = cnt_ff[ADDR_W-1:0];
   assign ram_wr_data = push_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_NORMAL;
         verb_ff    <= 8'd0;
         will_ff    <= 3'b000;
         do_ff      <= 3'b000;
         agreed_ff  <= 1'b0;
         cnt_ff     <= '0;
         ovf_ff     <= 1'b0;
         rd_idx_ff  <= '0;
         rep_idx_ff <= 2'd0;
      end else begin
         state_ff   <= state_in;
         verb_ff    <= verb_in;
         will_ff    <= will_in;
         do_ff      <= do_in;
         agreed_ff  <= agreed_in;
         cnt_ff     <= cnt_in;
         ovf_ff     <= ovf_in;
         rd_idx_ff  <= rd_idx_in;
         rep_idx_ff <= rep_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      opt_ff      <= opt_in;
      code_ff     <= code_in;
      rep_verb_ff <= rep_verb_in;
      rep_opt_ff  <= rep_opt_in;
   end

   `TCRD_ASSERT_IMPL(a_ovf_full, clock, reset, ovf_ff, cnt_ff == CNT_W'(SUBNEG_DEPTH))
   `TCRD_ASSERT_IMPL(a_push_ready, clock, reset, push_valid, out_ready)
   `TCRD_ASSERT_IMPL(a_rd_range, clock, reset, state_ff == ST_PUSH, (rd_idx_ff >= CNT_W'(2) && rd_idx_ff < cnt_ff))
   `TCRD_ASSERT_NEXT(a_rd_then_push, clock, reset, state_ff == ST_RD, state_ff == ST_PUSH)

endmodule

[src/telnet_comport_rx_decoder.sv]
// Top level of the Telnet receive decoder with COM-PORT option support.
// A data byte is registered and appears on the result side in the cycle after it is
// accepted. Unless the result side stalls, data bytes give one word per cycle and
// subnegotiation bytes are buffered one per cycle; a reply gives three words.
// Reset clears the parser, the option flags and the buffer count; no clearing pass.
`timescale 1ns / 1ps
module telnet_comport_rx_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_channel,
   output logic [7:0] rsp_out_byte,
   output logic [7:0] rsp_command_code,
   output logic       rsp_has_value,
   output logic       rsp_truncated,
   output logic       rsp_last,
   output logic       rsp_com_port_agreed
);
   import tcrd_pkg::*;

   logic              push_valid;
   rsp_word_type      push_word;
   logic              out_ready;
   rsp_word_type      rsp_word;
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [7:0]        ram_wr_data;
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;

   tcrd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_word   (push_word),
      .out_ready   (out_ready),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   tcrd_subneg_ram u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tcrd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_word  (push_word),
      .out_ready  (out_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

   assign rsp_channel         = rsp_word.channel;
   assign rsp_out_byte        = rsp_word.out_byte;
   assign rsp_command_code    = rsp_word.command_code;
   assign rsp_has_value       = rsp_word.has_value;
   assign rsp_truncated       = rsp_word.truncated;
   assign rsp_last            = rsp_word.last;
   assign rsp_com_port_agreed = rsp_word.com_port_agreed;

endmodule
